@@ sv/idr_pkg.sv @@
// ----------------------------------------------------------------------------
// idr_pkg: shared types and constants for the integer divide/remainder unit
// ----------------------------------------------------------------------------
package idr_pkg;

   localparam int unsigned DataWidth = 64;
   localparam int unsigned HalfWidth = 32;
   localparam int unsigned QueueDepthDefault = 4;

   typedef enum logic [1:0] {
      OP_UDIV32 = 2'd0,
      OP_SDIV32 = 2'd1,
      OP_UDIV64 = 2'd2,
      OP_SDIV64 = 2'd3
   } opcode_type;

   // classified request handed from front to back
   typedef struct packed {
      logic                 wide;
      logic                 zero_div;
      logic                 neg_quo;
      logic                 neg_rem;
      logic [DataWidth-1:0] num;
      logic [DataWidth-1:0] den;
   } job_type;

   typedef struct packed {
      logic [DataWidth-1:0] quotient;
      logic [DataWidth-1:0] remainder;
      logic                 div_by_zero;
   } result_type;

endpackage

@@ sv/idr_if.sv @@
// ----------------------------------------------------------------------------
// idr_req_if / idr_rsp_if: valid/ready channels of the divide unit
// ----------------------------------------------------------------------------
interface idr_req_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               opcode;
   logic [idr_pkg::DataWidth-1:0] dividend;
   logic [idr_pkg::DataWidth-1:0] divisor;
   modport source (output valid, output opcode, output dividend, output divisor,
                   input ready);
   modport sink (input valid, input opcode, input dividend, input divisor,
                 output ready);
endinterface

interface idr_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [idr_pkg::DataWidth-1:0] quotient;
   logic [idr_pkg::DataWidth-1:0] remainder;
   logic                     div_by_zero;
   modport source (output valid, output quotient, output remainder,
                   output div_by_zero, input ready);
   modport sink (input valid, input quotient, input remainder,
                 input div_by_zero, output ready);
endinterface

@@ sv/idr_front.sv @@
// ----------------------------------------------------------------------------
// idr_front: masks operands, takes magnitudes and records sign fixups
// ----------------------------------------------------------------------------
module idr_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [1:0]                    in_opcode,
   input  logic [idr_pkg::DataWidth-1:0] in_dividend,
   input  logic [idr_pkg::DataWidth-1:0] in_divisor,
   output logic                          out_valid,
   input  logic                          out_ready,
   output idr_pkg::job_type              out_job
);
   import idr_pkg::*;

   logic    valid_ff, valid_in;
   job_type job_ff, job_in;
   logic    wide, sgn, a_neg, b_neg;
   logic [DataWidth-1:0] mask, a, b;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      wide = (opcode_type'(in_opcode) == OP_UDIV64) || (opcode_type'(in_opcode) == OP_SDIV64);
      sgn  = (opcode_type'(in_opcode) == OP_SDIV32) || (opcode_type'(in_opcode) == OP_SDIV64);
      mask = wide ? '1 : {{HalfWidth{1'b0}}, {HalfWidth{1'b1}}};
      a = in_dividend & mask;
      b = in_divisor & mask;
      a_neg = sgn && (wide ? a[DataWidth-1] : a[HalfWidth-1]);
      b_neg = sgn && (wide ? b[DataWidth-1] : b[HalfWidth-1]);
      job_in.wide     = wide;
      job_in.zero_div = (b == '0);
      job_in.neg_quo  = a_neg ^ b_neg;
      job_in.neg_rem  = a_neg;
      job_in.num      = a_neg ? ((~a + 1'b1) & mask) : a;
      job_in.den      = b_neg ? ((~b + 1'b1) & mask) : b;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         job_ff <= job_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_job   = job_ff;
endmodule

@@ sv/idr_queue.sv @@
// ----------------------------------------------------------------------------
// idr_queue: small fifo between the front and the divider array
// ----------------------------------------------------------------------------
module idr_queue #(
   parameter int unsigned Depth = idr_pkg::QueueDepthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  idr_pkg::job_type in_job,
   output logic             out_valid,
   input  logic             out_ready,
   output idr_pkg::job_type out_job
);
   import idr_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

   job_type         mem_ff [Depth];
   logic [PtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]   cnt_ff, cnt_in;
   logic            push, pop;

   assign in_ready  = (cnt_ff != (PtrW+1)'(Depth));
   assign out_valid = (cnt_ff != '0);
   assign out_job   = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? ((wr_ff == PtrW'(Depth-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop ? ((rd_ff == PtrW'(Depth-1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= in_job;
      end
   end
endmodule

@@ sv/idr_back.sv @@
// ----------------------------------------------------------------------------
// idr_back: pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module idr_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  idr_pkg::job_type   in_job,
   output logic               out_valid,
   input  logic               out_ready,
   output idr_pkg::result_type out_result
);
   import idr_pkg::*;

   localparam int unsigned Stages = DataWidth;

   // per-stage state: job (num shifts in quotient bits), partial remainder
   logic    vld_ff [1:Stages];
   job_type job_ff [1:Stages];
   logic [DataWidth-1:0] rem_ff [1:Stages];
   // stage inputs: index 0 is the incoming request, index s the register after stage s-1
   logic    stg_vld [Stages+1];
   job_type stg_job [Stages+1];
   logic [DataWidth-1:0] stg_rem [Stages+1];
   logic    adv [Stages+1];
   logic    res_valid_ff;
   result_type res_ff, res_in;
   logic [DataWidth-1:0] mask, q, r;
   logic    last_ready;

   assign last_ready = !res_valid_ff || out_ready;

   always_comb begin
      stg_vld[0] = in_valid;
      stg_job[0] = in_job;
      stg_rem[0] = '0;
      for (int s = 1; s <= Stages; s++) begin
         stg_vld[s] = vld_ff[s];
         stg_job[s] = job_ff[s];
         stg_rem[s] = rem_ff[s];
      end
   end

   // a stage advances when it is empty or the stage after it advances; bubbles get squeezed out stage by stage
   always_comb begin
      adv[Stages] = !stg_vld[Stages] || last_ready;
      for (int s = Stages - 1; s >= 0; s--) begin
         adv[s] = !stg_vld[s] || adv[s+1];
      end
   end
   assign in_ready = adv[0];

   // stage s handles dividend bit DataWidth-1-s; 32-bit jobs skip the top half
   for (genvar s = 0; s < Stages; s++) begin : g_stage
      logic [DataWidth:0]   sh;
      logic [DataWidth-1:0] rnext;
      logic                 ge, act;
      job_type              jnext;
      always_comb begin
         act = stg_job[s].wide || (s >= HalfWidth);
         sh  = {stg_rem[s], stg_job[s].num[DataWidth-1]};
         ge  = (sh >= {1'b0, stg_job[s].den});
         rnext = act ? (ge ? DataWidth'(sh - {1'b0, stg_job[s].den}) : sh[DataWidth-1:0])
                     : stg_rem[s];
         // quotient bit enters at the bottom as the dividend bit leaves the top
         jnext     = stg_job[s];
         jnext.num = {stg_job[s].num[DataWidth-2:0], act && ge};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (adv[s+1]) begin
            vld_ff[s+1] <= stg_vld[s];
         end
         if (adv[s+1] && stg_vld[s]) begin
            job_ff[s+1] <= jnext;
            rem_ff[s+1] <= rnext;
         end
      end
   end

   always_comb begin
      mask = job_ff[Stages].wide ? '1 : {{HalfWidth{1'b0}}, {HalfWidth{1'b1}}};
      q = job_ff[Stages].num & mask;
      r = rem_ff[Stages];
      if (job_ff[Stages].neg_quo) q = (~q + 1'b1) & mask;
      if (job_ff[Stages].neg_rem) r = (~r + 1'b1) & mask;
      if (job_ff[Stages].zero_div) begin
         q = '0;
         r = '0;
      end
      res_in.quotient    = q;
      res_in.remainder   = r & mask;
      res_in.div_by_zero = job_ff[Stages].zero_div;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (last_ready) begin
         res_valid_ff <= vld_ff[Stages];
      end
      if (last_ready && vld_ff[Stages]) begin
         res_ff <= res_in;
      end
   end

   assign out_valid  = res_valid_ff;
   assign out_result = res_ff;
endmodule

@@ sv/integer_divide_remainder_unit.sv @@
// ----------------------------------------------------------------------------
// integer_divide_remainder_unit: signed/unsigned 32/64-bit divide and remainder
//
// Requests arrive on the req channel (opcode, dividend, divisor) and each
// gives exactly one response on the rsp channel (quotient, remainder,
// div_by_zero), in request order. Both are valid/ready handshakes.
// The front stage masks operands to the selected width and takes signed
// magnitudes; a small fifo decouples it from a 64-stage restoring divider
// pipeline, one quotient bit per stage, followed by a sign-fix output
// register. Throughput is one request per cycle while the receiver takes
// responses, set by the pipelined divider array.
// A receiver stall holds the output register and back-pressures the
// pipeline stage by stage; bubbles are squeezed out, and the fifo and
// front keep accepting until full. Synchronous reset empties every stage.
// ----------------------------------------------------------------------------
module integer_divide_remainder_unit #(
   parameter int unsigned QueueDepth = idr_pkg::QueueDepthDefault
) (
   input logic      clock,
   input logic      reset,
   idr_req_if.sink  req,
   idr_rsp_if.source rsp
);
   import idr_pkg::*;

   logic       f_valid, f_ready, q_valid, q_ready;
   job_type    f_job, q_job;
   result_type res;

   idr_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_opcode(req.opcode),
      .in_dividend(req.dividend), .in_divisor(req.divisor),
      .out_valid(f_valid), .out_ready(f_ready), .out_job(f_job)
   );

   idr_queue #(.Depth(QueueDepth)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
      .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
   );

   idr_back u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_job(q_job),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_result(res)
   );

   assign rsp.quotient    = res.quotient;
   assign rsp.remainder   = res.remainder;
   assign rsp.div_by_zero = res.div_by_zero;
endmodule

@@ tb/sv/integer_divide_remainder_unit_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_divide_remainder_unit_checker: quotient/remainder scoreboard
//
// Watches the request and response channels of the divide unit. For every
// accepted request it computes the expected quotient, remainder and
// divide-by-zero flag with its own shift-subtract divider, queues them, and
// compares each accepted response with the oldest queued entry.
// ----------------------------------------------------------------------------
module integer_divide_remainder_unit_checker
   import idr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   idr_req_if          req,
   idr_rsp_if          rsp,
   output int unsigned mismatch_count,
   output int unsigned pending_count,
   output int unsigned response_count,
   output int unsigned zero_div_count
);

   result_type quotient_fifo[$];

   function automatic result_type divide_request(logic [1:0] op, logic [63:0] num_raw,
                                                 logic [63:0] den_raw);
      result_type   res;
      logic         is_signed;
      logic         wide;
      int           width;
      logic [63:0]  mask;
      logic [63:0]  num;
      logic [63:0]  den;
      logic         num_neg;
      logic         den_neg;
      logic [64:0]  part;
      logic [63:0]  quo;
      is_signed = (op == OP_SDIV32) || (op == OP_SDIV64);
      wide      = (op == OP_UDIV64) || (op == OP_SDIV64);
      width     = wide ? 64 : 32;
      mask      = wide ? '1 : 64'h0000_0000_ffff_ffff;
      num       = num_raw & mask;
      den       = den_raw & mask;
      res       = '0;
      if (den == 0) begin
         res.div_by_zero = 1'b1;
         return res;
      end
      num_neg = is_signed && num[width-1];
      den_neg = is_signed && den[width-1];
      if (num_neg) num = (-num) & mask;
      if (den_neg) den = (-den) & mask;
      part = '0;
      quo  = '0;
      for (int i = width - 1; i >= 0; i--) begin
         part = {part[63:0], num[i]};
         quo  = quo << 1;
         if (part >= {1'b0, den}) begin
            part   = part - {1'b0, den};
            quo[0] = 1'b1;
         end
      end
      if (num_neg != den_neg) quo = -quo;
      res.quotient  = quo & mask;
      res.remainder = (num_neg ? -part[63:0] : part[63:0]) & mask;
      return res;
   endfunction

   assign pending_count = quotient_fifo.size();

   always @(posedge clock) begin
      result_type exp_res;
      if (reset) begin
         quotient_fifo.delete();
         mismatch_count <= 0;
         response_count <= 0;
         zero_div_count <= 0;
      end else begin
         if (req.valid && req.ready)
            quotient_fifo.push_back(divide_request(req.opcode, req.dividend, req.divisor));
         if (rsp.valid && rsp.ready) begin
            response_count <= response_count + 1;
            if (rsp.div_by_zero) zero_div_count <= zero_div_count + 1;
            if (quotient_fifo.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("%0t: unexpected response q=%h r=%h dz=%b", $realtime,
                           rsp.quotient, rsp.remainder, rsp.div_by_zero);
            end else begin
               exp_res = quotient_fifo.pop_front();
               if (rsp.quotient !== exp_res.quotient || rsp.remainder !== exp_res.remainder
                   || rsp.div_by_zero !== exp_res.div_by_zero) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display("%0t: exp q=%h r=%h dz=%b got q=%h r=%h dz=%b", $realtime,
                              exp_res.quotient, exp_res.remainder, exp_res.div_by_zero,
                              rsp.quotient, rsp.remainder, rsp.div_by_zero);
               end
            end
         end
      end
   end

endmodule

@@ tb/sv/integer_divide_remainder_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_divide_remainder_unit_tb: top of the divide unit testbench
//
// Drives directed corner requests (zero divisors, most negative dividends,
// all opcodes, stray upper bits) and then random bursts with random gaps,
// while the receiver stalls on its own pattern. The checker does the scoring.
// ----------------------------------------------------------------------------
module integer_divide_remainder_unit_tb;
   import idr_pkg::*;

   localparam int unsigned RandomCount = 1130;
   localparam int unsigned IdleLimit   = 5000;

   logic        clock;
   logic        reset;
   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned response_count;
   int unsigned zero_div_count;
   int unsigned idle_cycles;
   logic        stall_mode;

   idr_req_if req ();
   idr_rsp_if rsp ();

   integer_divide_remainder_unit i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   integer_divide_remainder_unit_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req            (req),
      .rsp            (rsp),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .response_count (response_count),
      .zero_div_count (zero_div_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [63:0] random_operand();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: v = v & 64'hff;
         1: v = v >> $urandom_range(1, 63);
         2: v = {32'h0, v[31:0]};
         3: v = '1 - (v & 64'hf);
         4: v = {{33{v[0]}}, 31'h0} | (v & 64'h3);
         5: v = {v[63:32], 32'h0};
         default: ;
      endcase
      return v;
   endfunction

   // hold one request until accepted
   task automatic send_request(logic [1:0] op, logic [63:0] num, logic [63:0] den);
      req.valid    <= 1'b1;
      req.opcode   <= op;
      req.dividend <= num;
      req.divisor  <= den;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic go_idle(int unsigned cycles);
      req.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // receiver stall pattern: long open stretches, then random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready  <= 1'b0;
         stall_mode <= 1'b0;
      end else begin
         if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
         rsp.ready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   always @(posedge clock) begin
      if (idle_cycles >= IdleLimit) begin
         $display("watchdog: %0d idle cycles", idle_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      logic [63:0] min64;
      logic [63:0] min32;
      int unsigned burst;
      min64 = 64'h8000_0000_0000_0000;
      min32 = 64'h0000_0000_8000_0000;
      reset        = 1'b1;
      req.valid    = 1'b0;
      req.opcode   = OP_UDIV32;
      req.dividend = '0;
      req.divisor  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      send_request(OP_UDIV32, 64'd100, 64'd7);
      send_request(OP_SDIV32, 64'hffff_ffff_ffff_ff9c, 64'd7);
      send_request(OP_UDIV64, '1, 64'd3);
      send_request(OP_SDIV64, 64'd100, -64'd7);
      send_request(OP_UDIV32, 64'd5, 64'd0);
      send_request(OP_SDIV64, 64'd5, 64'd0);
      send_request(OP_UDIV32, 64'd5, 64'hffff_0000_0000_0000);
      send_request(OP_SDIV32, 64'd5, 64'h1234_5678_0000_0000);
      send_request(OP_SDIV32, min32, 64'hffff_ffff);
      send_request(OP_SDIV64, min64, '1);
      send_request(OP_SDIV32, min32, 64'd1);
      send_request(OP_SDIV64, min64, min64);
      send_request(OP_SDIV64, 64'd0, -64'd3);
      send_request(OP_SDIV32, 64'd0, 64'hffff_fffd);
      send_request(OP_UDIV64, '1, '1);
      send_request(OP_UDIV64, 64'd1, '1);
      send_request(OP_UDIV32, '1, '1);
      send_request(OP_UDIV32, 64'hdead_beef_ffff_ffff, 64'h1);
      send_request(OP_SDIV64, 64'h7fff_ffff_ffff_ffff, min64);
      send_request(OP_SDIV32, 64'h7fff_ffff, 64'h8000_0000);
      go_idle(0);

      // drain fully before the random phase
      do @(posedge clock); while (pending_count != 0);

      for (int unsigned n = 0; n < RandomCount; ) begin
         burst = $urandom_range(1, 40);
         for (int unsigned k = 0; k < burst && n < RandomCount; k++, n++) begin
            logic [63:0] den;
            den = random_operand();
            if ($urandom_range(0, 31) == 0) den = $urandom_range(0, 1) ? '0 : {$urandom, 32'h0};
            send_request(2'($urandom_range(0, 3)), random_operand(), den);
         end
         if ($urandom_range(0, 3) != 0)
            go_idle($urandom_range(0, 12));
         if (n > RandomCount / 2 && n < RandomCount / 2 + 41) begin
            req.valid <= 1'b0;
            do @(posedge clock); while (pending_count != 0);
         end
      end
      req.valid <= 1'b0;

      do @(posedge clock); while (pending_count != 0);
      repeat (100) @(posedge clock);
      $display("covered %0d divisions across all four opcodes, %0d with zero divisor",
               response_count, zero_div_count);
      if (mismatch_count == 0 && pending_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
